### sv/dual_channel_moving_average_assert.svh
// Assertion macros shared by the moving average block.
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCMA_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dcma_pkg.sv
package dcma_pkg;

    // Window geometry.
    localparam int WINDOW_LEN = 30;
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int LEN_LOG    = $clog2(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    // Field widths.
    localparam int RAW_W   = 12;
    localparam int VOLT_W  = 13;
    localparam int CURR_W  = 12;
    localparam int THOU_W  = 3;
    localparam int DIGIT_W = 4;

    // Largest calibrated values.
    localparam int VOLT_MAX = 6595;
    localparam int CURR_MAX = 3276;

    // Voltage calibration, unsigned Q16 gain and offset.
    localparam int V_GAIN_W    = 17;
    localparam int VPROD_W     = V_GAIN_W + RAW_W;
    localparam int V_FRAC_BITS = 16;
    localparam logic [V_GAIN_W-1:0] V_GAIN   = 17'd105690;
    localparam logic [VPROD_W-1:0]  V_OFFSET = 29'd547960;

    // Current scaling: raw*8/10 is (raw*4)/5, done as a multiply by ceil(2^18/5).
    localparam int C_MUL_W = 16;
    localparam int C_SHIFT = 18;
    localparam int CPROD_W = RAW_W + 2 + C_MUL_W;
    localparam logic [C_MUL_W-1:0] C_MUL = 16'd52429;

    // Running sums.
    localparam int VSUM_W = $clog2(WINDOW_LEN * VOLT_MAX + 1);
    localparam int CSUM_W = $clog2(WINDOW_LEN * CURR_MAX + 1);

    // Division of the sums by the window length through a reciprocal.
    localparam int V_DIV_SHIFT  = VSUM_W + LEN_LOG;
    localparam int C_DIV_SHIFT  = CSUM_W + LEN_LOG;
    localparam int V_DIV_PROD_W = 2 * VSUM_W + 1;
    localparam int C_DIV_PROD_W = 2 * CSUM_W + 1;
    localparam logic [VSUM_W:0] V_DIV_MUL = (VSUM_W + 1)'(
        ((64'd1 << V_DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [CSUM_W:0] C_DIV_MUL = (CSUM_W + 1)'(
        ((64'd1 << C_DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Decimal split of the selected average.
    localparam int SEL_W      = VOLT_W;
    localparam int DIG_MUL_W  = SEL_W + 1;
    localparam int DIG_PROD_W = 2 * SEL_W + 1;
    localparam int SEL_MAX    = (1 << SEL_W) - 1;
    localparam int D10_SHIFT   = SEL_W + $clog2(10);
    localparam int D100_SHIFT  = SEL_W + $clog2(100);
    localparam int D1000_SHIFT = SEL_W + $clog2(1000);
    localparam logic [DIG_MUL_W-1:0] D10_MUL = DIG_MUL_W'(
        ((64'd1 << D10_SHIFT) + 64'd9) / 64'd10);
    localparam logic [DIG_MUL_W-1:0] D100_MUL = DIG_MUL_W'(
        ((64'd1 << D100_SHIFT) + 64'd99) / 64'd100);
    localparam logic [DIG_MUL_W-1:0] D1000_MUL = DIG_MUL_W'(
        ((64'd1 << D1000_SHIFT) + 64'd999) / 64'd1000);
    localparam int Q10_W   = $clog2(SEL_MAX / 10 + 1);
    localparam int Q100_W  = $clog2(SEL_MAX / 100 + 1);
    localparam int Q1000_W = $clog2(SEL_MAX / 1000 + 1);

    // Register port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SHOW_VOLTAGE = 1'b0;

    typedef struct packed {
        logic [RAW_W-1:0] voltage_raw;
        logic [RAW_W-1:0] current_raw;
    } dcma_in_t;

    typedef struct packed {
        logic [VOLT_W-1:0]  voltage_average;
        logic [CURR_W-1:0]  current_average;
        logic [THOU_W-1:0]  digit_thousands;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_units;
    } dcma_out_t;

    // One window entry holds both channels.
    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [CURR_W-1:0] curr;
    } dcma_entry_t;

    typedef struct packed {
        logic load_p3;
        logic load_p4;
        logic load_p5;
    } dcma_pipe_ctrl_t;

endpackage

### sv/dcma_window_ram.sv
module dcma_window_ram
    import dcma_pkg::*;
(
    input  logic             clk,
    input  logic             rstn,
    input  logic             rd_en,
    input  logic [POS_W-1:0] rd_addr,
    output dcma_entry_t      rd_data,
    input  logic             wr_en,
    input  logic [POS_W-1:0] wr_addr,
    input  dcma_entry_t      wr_data
);

    dcma_entry_t mem [WINDOW_LEN];
    dcma_entry_t rd_data_reg;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### sv/dcma_avg_digits.sv
module dcma_avg_digits
    import dcma_pkg::*;
(
    input  logic              clk,
    input  dcma_pipe_ctrl_t   ctrl,
    input  logic              show_voltage,
    input  logic [VSUM_W-1:0] vsum,
    input  logic [CSUM_W-1:0] csum,
    output dcma_out_t         result
);

    logic [V_DIV_PROD_W-1:0] vprod_reg;
    logic [C_DIV_PROD_W-1:0] cprod_reg;

    logic [VOLT_W-1:0]  vavg;
    logic [CURR_W-1:0]  cavg;
    logic [SEL_W-1:0]   sel;
    logic [DIG_PROD_W-1:0] d10_prod;
    logic [DIG_PROD_W-1:0] d100_prod;
    logic [DIG_PROD_W-1:0] d1000_prod;

    logic [VOLT_W-1:0]  vavg_reg;
    logic [CURR_W-1:0]  cavg_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [Q10_W-1:0]   q10_reg;
    logic [Q100_W-1:0]  q100_reg;
    logic [Q1000_W-1:0] q1000_reg;

    logic [SEL_W-1:0]   units_wide;
    logic [Q10_W-1:0]   tens_wide;
    logic [Q100_W-1:0]  hundreds_wide;
    dcma_out_t result_next;
    dcma_out_t result_reg;

    // Stage three: sums times the reciprocal of the window length.
    always_ff @(posedge clk) begin
        if (ctrl.load_p3) begin
            vprod_reg <= V_DIV_PROD_W'(vsum) * V_DIV_PROD_W'(V_DIV_MUL);
            cprod_reg <= C_DIV_PROD_W'(csum) * C_DIV_PROD_W'(C_DIV_MUL);
        end
    end

    // Stage four: averages, selection and the three decimal quotients.
    always_comb begin
        vavg       = vprod_reg[V_DIV_SHIFT +: VOLT_W];
        cavg       = cprod_reg[C_DIV_SHIFT +: CURR_W];
        sel        = show_voltage ? vavg : SEL_W'(cavg);
        d10_prod   = DIG_PROD_W'(sel) * DIG_PROD_W'(D10_MUL);
        d100_prod  = DIG_PROD_W'(sel) * DIG_PROD_W'(D100_MUL);
        d1000_prod = DIG_PROD_W'(sel) * DIG_PROD_W'(D1000_MUL);
    end

    always_ff @(posedge clk) begin
        if (ctrl.load_p4) begin
            vavg_reg  <= vavg;
            cavg_reg  <= cavg;
            sel_reg   <= sel;
            q10_reg   <= d10_prod[D10_SHIFT +: Q10_W];
            q100_reg  <= d100_prod[D100_SHIFT +: Q100_W];
            q1000_reg <= d1000_prod[D1000_SHIFT +: Q1000_W];
        end
    end

    // Stage five: each digit is a quotient less ten times the next one up.
    always_comb begin
        units_wide = sel_reg - (SEL_W'({q10_reg, 3'b000}) + SEL_W'({q10_reg, 1'b0}));
        tens_wide = q10_reg - (Q10_W'({q100_reg, 3'b000}) + Q10_W'({q100_reg, 1'b0}));
        hundreds_wide = q100_reg
                      - (Q100_W'({q1000_reg, 3'b000}) + Q100_W'({q1000_reg, 1'b0}));
        result_next.voltage_average = vavg_reg;
        result_next.current_average = cavg_reg;
        result_next.digit_thousands = q1000_reg[THOU_W-1:0];
        result_next.digit_hundreds  = hundreds_wide[DIGIT_W-1:0];
        result_next.digit_tens      = tens_wide[DIGIT_W-1:0];
        result_next.digit_units     = units_wide[DIGIT_W-1:0];
    end

    always_ff @(posedge clk) begin
        if (ctrl.load_p5) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### sv/dual_channel_moving_average.sv
// Dual-channel boxcar moving average. Each item carries one raw voltage and one
// raw current sample. Voltage is calibrated as 1.6127*raw - 8.3612 (Q16,
// truncated, negative results held at zero) and current is scaled by 8/10; both
// enter 30-deep sliding windows with running sums, and each result item carries
// both averages plus the four decimal digits of the average chosen by the
// show_voltage register (word 0 of the register port, bit 0). One item is taken
// per clock cycle when the output side keeps up; the windows live in a single memory
// that is read when an item is accepted and written back as that item moves into
// stage two, so the rate is set by that one read and one write per item. Bubbles
// in the pipeline collapse, so a waiting result does not stop new items coming in
// until every stage is full. The windows read as zero straight after reset through
// per-entry valid flags, so there is no clearing pass and the first averages
// include the empty entries.
`include "dual_channel_moving_average_assert.svh"

module dual_channel_moving_average
    import dcma_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  dcma_in_t          s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output dcma_out_t         m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Register port. The only register is show_voltage; writes to any
    // other word are dropped and reads of them return zero.
    // ------------------------------------------------------------------
    logic show_voltage_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_voltage_reg <= 1'b0;
        end else if (cfg_write && (paddr[ADDR_W-1:2] == REG_SHOW_VOLTAGE)) begin
            show_voltage_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_SHOW_VOLTAGE) begin
            prdata[0] = show_voltage_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads whenever it is empty or the
    // stage after it is moving, so any empty stage absorbs a stall.
    // Stage one holds the calibration products and the window read,
    // stage two marks the item whose sums are in the running sum
    // registers, stages three to five sit in the averaging unit and
    // stage five is the output register.
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic accept;
    logic adv1;
    dcma_pipe_ctrl_t pipe_ctrl;

    assign rdy5 = !p5_valid_reg || m_ready;
    assign rdy4 = !p4_valid_reg || rdy5;
    assign rdy3 = !p3_valid_reg || rdy4;
    assign rdy2 = !p2_valid_reg || rdy3;
    assign rdy1 = !p1_valid_reg || rdy2;

    assign s_ready = rdy1;
    assign m_valid = p5_valid_reg;
    assign accept  = s_valid && rdy1;
    assign adv1    = p1_valid_reg && rdy2;

    assign pipe_ctrl.load_p3 = p2_valid_reg && rdy3;
    assign pipe_ctrl.load_p4 = p3_valid_reg && rdy4;
    assign pipe_ctrl.load_p5 = p4_valid_reg && rdy5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                p1_valid_reg <= s_valid;
            end
            if (rdy2) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (rdy3) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (rdy4) begin
                p4_valid_reg <= p3_valid_reg;
            end
            if (rdy5) begin
                p5_valid_reg <= p4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring position: the entry that the accepted item replaces.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    assign pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage one. The calibration multiplications are registered, and the
    // window memory is read at the replaced entry in the same cycle.
    // ------------------------------------------------------------------
    logic [VPROD_W-1:0] p1_vprod_reg;
    logic [CPROD_W-1:0] p1_cprod_reg;
    logic [POS_W-1:0]   p1_pos_reg;
    logic               p1_fwd_hit_reg;
    dcma_entry_t        p1_fwd_data_reg;
    logic               fwd_hit;

    dcma_entry_t ram_rd_data;
    dcma_entry_t new_entry;
    dcma_entry_t old_entry;
    logic [VPROD_W-1:0] v_diff;

    // The memory read misses a write landing on the same edge. That can
    // only be the item directly ahead writing the very entry being read,
    // which happens with a one-entry window, so its value is captured here.
    assign fwd_hit = adv1 && (p1_pos_reg == pos_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_vprod_reg    <= VPROD_W'(s_data.voltage_raw) * VPROD_W'(V_GAIN);
            p1_cprod_reg    <= CPROD_W'({s_data.current_raw, 2'b00}) * CPROD_W'(C_MUL);
            p1_pos_reg      <= pos_reg;
            p1_fwd_hit_reg  <= fwd_hit;
            p1_fwd_data_reg <= new_entry;
        end
    end

    dcma_window_ram u_window_ram (
        .clk     (aclk),
        .rstn    (aresetn),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data),
        .wr_en   (adv1),
        .wr_addr (p1_pos_reg),
        .wr_data (new_entry)
    );

    // Finish calibration: subtract the offset, clamp below zero, drop the
    // fraction. Current keeps the integer part of the reciprocal product.
    always_comb begin
        v_diff = p1_vprod_reg - V_OFFSET;
        if (p1_vprod_reg < V_OFFSET) begin
            new_entry.volt = '0;
        end else begin
            new_entry.volt = v_diff[V_FRAC_BITS +: VOLT_W];
        end
        new_entry.curr = p1_cprod_reg[C_SHIFT +: CURR_W];
        old_entry = p1_fwd_hit_reg ? p1_fwd_data_reg : ram_rd_data;
    end

    // ------------------------------------------------------------------
    // Running sums. They move on when the stage-one item moves into stage
    // two, so while an item is in stage two they hold exactly its sums;
    // the averaging unit samples them as that item leaves.
    // ------------------------------------------------------------------
    logic [VSUM_W-1:0] vsum_reg;
    logic [VSUM_W-1:0] vsum_next;
    logic [CSUM_W-1:0] csum_reg;
    logic [CSUM_W-1:0] csum_next;

    assign vsum_next = vsum_reg + VSUM_W'(new_entry.volt) - VSUM_W'(old_entry.volt);
    assign csum_next = csum_reg + CSUM_W'(new_entry.curr) - CSUM_W'(old_entry.curr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsum_reg <= '0;
            csum_reg <= '0;
        end else if (adv1) begin
            vsum_reg <= vsum_next;
            csum_reg <= csum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages three to five: division by the window length and the
    // decimal digits.
    // ------------------------------------------------------------------
    dcma_avg_digits u_avg_digits (
        .clk          (aclk),
        .ctrl         (pipe_ctrl),
        .show_voltage (show_voltage_reg),
        .vsum         (vsum_reg),
        .csum         (csum_reg),
        .result       (m_data)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `DCMA_ASSERT(a_ring_in_range, aclk, aresetn, 1'b1, int'(pos_reg) < WINDOW_LEN, "ring position beyond window")
    `DCMA_ASSERT_NEXT(a_ring_steps, aclk, aresetn, accept, (pos_reg != $past(pos_reg)) || (WINDOW_LEN == 1), "ring position did not advance")
    `DCMA_ASSERT(a_vsum_bound, aclk, aresetn, 1'b1, int'(vsum_reg) <= WINDOW_LEN * VOLT_MAX, "voltage sum out of range")
    `DCMA_ASSERT(a_fwd_one_entry, aclk, aresetn, p1_valid_reg && p1_fwd_hit_reg, WINDOW_LEN == 1, "unexpected write forwarding")

endmodule
